// ===== rtl/ttcw_pkg.sv =====
// shared constants, types and command/status structs for the text terminal cell writer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ttcw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int IDX_W   = 11;

  // digit generation
  localparam int VALUE_W      = 32;
  localparam int MAX_DIGITS   = 32;
  localparam int DIGIT_AW     = $clog2(MAX_DIGITS);
  localparam int BITS_PER_CYC = 8;
  localparam int DIV_CYCLES   = VALUE_W / BITS_PER_CYC;
  localparam int STEP_W       = $clog2(DIV_CYCLES);

  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam logic [5:0] RADIX_DEC = 6'd10;

  // character codes
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ALPHA   = 8'h37;

  // request modes
  localparam logic [1:0] MODE_CHAR   = 2'd0;
  localparam logic [1:0] MODE_SDEC   = 2'd1;
  localparam logic [1:0] MODE_RADIX  = 2'd2;
  localparam logic [1:0] MODE_AT_POS = 2'd3;

  // config register indexes
  localparam logic [0:0] REG_WHITE_ATTR = 1'd0;
  localparam logic [7:0] WHITE_ATTR_RST = 8'd15;

  typedef enum logic [1:0] {
    SRC_CHAR,
    SRC_SIGN,
    SRC_DIGIT
  } ttcw_src_t;

  typedef struct packed {
    logic      load;
    logic      div_step;
    logic      emit;
    ttcw_src_t src;
  } ttcw_cmd_t;

  typedef struct packed {
    logic newline;
    logic pos_ok;
    logic neg;
    logic digit_done;
    logic quo_zero;
    logic last_digit;
    logic slot_free;
  } ttcw_status_t;

endpackage

// ===== rtl/ttcw_ctrl.sv =====
// sequencing state machine for the text terminal cell writer
// depends on ttcw_pkg; drives commands into ttcw_datapath
`timescale 1ns / 1ps

module ttcw_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic [1:0]            mode,
  input  ttcw_pkg::ttcw_status_t status,
  output ttcw_pkg::ttcw_cmd_t   cmd,
  output logic                  item_stall
);
  import ttcw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAR,
    ST_SIGN,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.src    = SRC_CHAR;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          unique case (mode)
            MODE_CHAR:   state_next = status.newline ? ST_IDLE : ST_CHAR;
            MODE_SDEC:   state_next = status.neg ? ST_SIGN : ST_DIV;
            MODE_RADIX:  state_next = ST_DIV;
            MODE_AT_POS: state_next = status.pos_ok ? ST_DIV : ST_IDLE;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_CHAR: begin
        cmd.src = SRC_CHAR;
        if (status.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SIGN: begin
        cmd.src = SRC_SIGN;
        if (status.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.digit_done && status.quo_zero) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.src = SRC_DIGIT;
        if (status.slot_free) begin
          cmd.emit = 1'b1;
          if (status.last_digit) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/ttcw_datapath.sv =====
// cursor, radix divider, digit stack and output register of the text terminal cell writer
// depends on ttcw_pkg; steered by ttcw_ctrl
`timescale 1ns / 1ps

module ttcw_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  ttcw_pkg::ttcw_cmd_t             cmd,
  output ttcw_pkg::ttcw_status_t          status,
  input  logic [7:0]                      white_attr,
  input  logic [1:0]                      mode,
  input  logic [7:0]                      char_code,
  input  logic [7:0]                      attribute,
  input  logic [ttcw_pkg::VALUE_W-1:0]    value,
  input  logic [5:0]                      radix,
  input  logic [7:0]                      pos_col,
  input  logic [7:0]                      pos_row,
  output logic                            cell_valid,
  input  logic                            cell_stall,
  output logic [ttcw_pkg::IDX_W-1:0]      cell_index,
  output logic [15:0]                     cell_word,
  output logic                            last
);
  import ttcw_pkg::*;

  logic [COL_W-1:0]   cursor_col;
  logic [ROW_W-1:0]   cursor_row;
  logic [COL_W-1:0]   save_col;
  logic [ROW_W-1:0]   save_row;
  logic               restore;
  logic [7:0]         char_r;
  logic [7:0]         attr_r;

  logic [VALUE_W-1:0] work;
  logic [5:0]         rem;
  logic [5:0]         radix_r;
  logic [STEP_W-1:0]  step;
  logic [5:0]         digits [MAX_DIGITS];
  logic [DIGIT_AW:0]  dcount;
  logic [DIGIT_AW:0]  dcount_m1;
  logic [DIGIT_AW:0]  dcount_m2;

  logic [VALUE_W-1:0] work_next;
  logic [5:0]         rem_next;
  logic [6:0]         trial;
  logic               step_done;

  logic [COL_W-1:0]   adv_col;
  logic [ROW_W-1:0]   adv_row;
  logic [COL_W-1:0]   nl_col;
  logic [ROW_W-1:0]   nl_row;
  logic [ROW_W:0]     row_inc;
  logic [COL_W:0]     col_inc;

  logic [5:0]         radix_clamped;
  logic [5:0]         top_digit;
  logic [7:0]         digit_char;
  logic [7:0]         emit_char;
  logic [7:0]         emit_attr;
  logic               emit_last;
  logic [IDX_W-1:0]   cur_index;

  // eight restoring-division steps per cycle on the small remainder
  always_comb begin
    rem_next  = rem;
    work_next = work;
    trial     = '0;
    for (int i = 0; i < BITS_PER_CYC; i++) begin
      trial     = {rem_next, work_next[VALUE_W-1]};
      work_next = {work_next[VALUE_W-2:0], 1'b0};
      if (trial >= {1'b0, radix_r}) begin
        trial        = trial - {1'b0, radix_r};
        work_next[0] = 1'b1;
      end
      rem_next = trial[5:0];
    end
  end

  assign step_done = cmd.div_step && (step == STEP_W'(DIV_CYCLES - 1));

  // cursor movement after a cell and after a newline
  always_comb begin
    col_inc = {1'b0, cursor_col} + 1'b1;
    row_inc = {1'b0, cursor_row} + 1'b1;
    adv_col = cursor_col + 1'b1;
    adv_row = cursor_row;
    if (col_inc >= (COL_W + 1)'(COLUMNS)) begin
      adv_col = '0;
      adv_row = row_inc[ROW_W-1:0];
      if (row_inc >= (ROW_W + 1)'(ROWS)) begin
        adv_row = '0;
      end
    end
    nl_col = '0;
    nl_row = (row_inc >= (ROW_W + 1)'(ROWS)) ? '0 : row_inc[ROW_W-1:0];
  end

  always_comb begin
    if (radix < RADIX_MIN) begin
      radix_clamped = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_clamped = RADIX_MAX;
    end else begin
      radix_clamped = radix;
    end
  end

  assign dcount_m1  = dcount - 1'b1;
  assign dcount_m2  = dcount - 2'd2;
  assign digit_char = (top_digit > 6'd9) ? (8'(top_digit) + CH_ALPHA)
                                         : (8'(top_digit) + CH_ZERO);
  assign cur_index  = IDX_W'(32'(cursor_row) * COLUMNS + 32'(cursor_col));

  always_comb begin
    unique case (cmd.src)
      SRC_CHAR: begin
        emit_char = char_r;
        emit_attr = attr_r;
        emit_last = 1'b1;
      end
      SRC_SIGN: begin
        emit_char = CH_MINUS;
        emit_attr = white_attr;
        emit_last = 1'b0;
      end
      SRC_DIGIT: begin
        emit_char = digit_char;
        emit_attr = white_attr;
        emit_last = (dcount == (DIGIT_AW + 1)'(1));
      end
      default: begin
        emit_char = char_r;
        emit_attr = attr_r;
        emit_last = 1'b1;
      end
    endcase
  end

  assign status.newline    = (char_code == CH_NEWLINE);
  assign status.pos_ok     = (pos_col < 8'(COLUMNS)) && (pos_row < 8'(ROWS));
  assign status.neg        = value[VALUE_W-1];
  assign status.digit_done = step_done;
  assign status.quo_zero   = (work_next == '0);
  assign status.last_digit = (dcount == (DIGIT_AW + 1)'(1));
  assign status.slot_free  = !cell_valid || !cell_stall;

  // control and cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      restore    <= 1'b0;
      step       <= '0;
      dcount     <= '0;
      cell_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        cell_valid <= 1'b1;
      end else if (!cell_stall) begin
        cell_valid <= 1'b0;
      end

      if (cmd.load) begin
        step    <= '0;
        dcount  <= '0;
        restore <= 1'b0;
        unique case (mode)
          MODE_CHAR: begin
            if (status.newline) begin
              cursor_col <= nl_col;
              cursor_row <= nl_row;
            end
          end
          MODE_AT_POS: begin
            if (status.pos_ok) begin
              cursor_col <= pos_col[COL_W-1:0];
              cursor_row <= pos_row[ROW_W-1:0];
              restore    <= 1'b1;
            end
          end
          default: ;
        endcase
      end

      if (cmd.div_step) begin
        if (step_done) begin
          step   <= '0;
          dcount <= dcount + 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end

      if (cmd.emit) begin
        if (cmd.src == SRC_DIGIT) begin
          dcount <= dcount_m1;
        end
        if (cmd.src == SRC_DIGIT && emit_last && restore) begin
          cursor_col <= save_col;
          cursor_row <= save_row;
        end else begin
          cursor_col <= adv_col;
          cursor_row <= adv_row;
        end
      end
    end
  end

  // payload: operands, remainder, digit stack and the output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r   <= char_code;
      attr_r   <= attribute;
      rem      <= '0;
      save_col <= cursor_col;
      save_row <= cursor_row;
      if (mode == MODE_SDEC) begin
        work    <= value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
        radix_r <= RADIX_DEC;
      end else begin
        work    <= value;
        radix_r <= radix_clamped;
      end
    end
    if (cmd.div_step) begin
      work <= work_next;
      rem  <= step_done ? 6'd0 : rem_next;
      if (step_done) begin
        digits[dcount[DIGIT_AW-1:0]] <= rem_next;
      end
    end
    // top of the digit stack: the new digit on a push, the one beneath on a pop
    if (cmd.div_step && step_done) begin
      top_digit <= rem_next;
    end else if (cmd.emit && cmd.src == SRC_DIGIT) begin
      top_digit <= digits[dcount_m2[DIGIT_AW-1:0]];
    end
    if (cmd.emit) begin
      cell_index <= cur_index;
      cell_word  <= {emit_attr, emit_char};
      last       <= emit_last;
    end
  end

endmodule

// ===== rtl/text_terminal_cell_writer.sv =====
// text terminal cell writer: top level with the configuration register
// depends on ttcw_pkg, ttcw_ctrl and ttcw_datapath
//
// usage
//   item channel (item_valid / item_stall) takes one request: put a character,
//   print a signed decimal, print an unsigned value in radix 2..36, or print
//   one at a given screen position and then put the cursor back.
//   cell channel (cell_valid / cell_stall) gives one transfer per cell write,
//   last marks the final cell of a request; newlines and rejected positions
//   give no transfer at all.
//   the apb port holds white_attr at address 0, used for digits and the sign.
// timing
//   one request at a time: item_stall is high from the cycle after a transfer
//   until its last cell sits in the output register.
//   a character is loaded, then written as one cell. a number is loaded, its
//   sign cell (if a negative decimal) is written, the radix divider (8 quotient
//   bits a cycle) pushes one digit at a time until the quotient is zero, then
//   one cell per digit is written, most significant first.
// reset and stall
//   reset clears the cursor to the top left, white_attr to 15, and drops
//   cell_valid. while cell_stall is high a valid output cell is held and the
//   sequencer waits before writing the next cell; the next request is taken
//   as soon as the last cell of the previous one is in the output register.
`timescale 1ns / 1ps

module text_terminal_cell_writer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [1:0]                   mode,
  input  logic [7:0]                   char_code,
  input  logic [7:0]                   attribute,
  input  logic [ttcw_pkg::VALUE_W-1:0] value,
  input  logic [5:0]                   radix,
  input  logic [7:0]                   pos_col,
  input  logic [7:0]                   pos_row,
  output logic                         cell_valid,
  input  logic                         cell_stall,
  output logic [ttcw_pkg::IDX_W-1:0]   cell_index,
  output logic [15:0]                  cell_word,
  output logic                         last
);
  import ttcw_pkg::*;

  logic [7:0]   white_attr;
  logic [0:0]   reg_sel;
  ttcw_cmd_t    cmd;
  ttcw_status_t status;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2:2];
  assign prdata  = (reg_sel == REG_WHITE_ATTR) ? {24'd0, white_attr} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      white_attr <= WHITE_ATTR_RST;
    end else if (psel && penable && pwrite && pready && reg_sel == REG_WHITE_ATTR) begin
      white_attr <= pwdata[7:0];
    end
  end

  ttcw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .mode       (mode),
    .status     (status),
    .cmd        (cmd),
    .item_stall (item_stall)
  );

  ttcw_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .white_attr (white_attr),
    .mode       (mode),
    .char_code  (char_code),
    .attribute  (attribute),
    .value      (value),
    .radix      (radix),
    .pos_col    (pos_col),
    .pos_row    (pos_row),
    .cell_valid (cell_valid),
    .cell_stall (cell_stall),
    .cell_index (cell_index),
    .cell_word  (cell_word),
    .last       (last)
  );

endmodule

// ===== rtl/ttcw_checker.sv =====
// port-level checks for the text terminal cell writer, bound to the top level
// depends on ttcw_pkg and text_terminal_cell_writer
`timescale 1ns / 1ps

module ttcw_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         item_valid,
  input logic                         item_stall,
  input logic [1:0]                   mode,
  input logic [7:0]                   char_code,
  input logic [7:0]                   pos_col,
  input logic [7:0]                   pos_row,
  input logic                         cell_valid,
  input logic                         cell_stall,
  input logic [ttcw_pkg::IDX_W-1:0]   cell_index,
  input logic [15:0]                  cell_word,
  input logic                         last
);
  import ttcw_pkg::*;

  // a stalled cell transfer keeps its payload
  a_cell_hold: assert property (@(posedge clk) disable iff (rst)
    cell_valid && cell_stall |=>
      cell_valid && $stable(cell_index) && $stable(cell_word) && $stable(last))
    else $error("cell payload changed under stall");

  // every cell lands on the screen
  a_cell_on_screen: assert property (@(posedge clk) disable iff (rst)
    cell_valid |-> (32'(cell_index) < CELLS))
    else $error("cell index beyond the screen");

  // a printable character that is taken sets the block busy
  a_char_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && mode == MODE_CHAR && char_code != CH_NEWLINE
      |=> item_stall)
    else $error("printable character did not occupy the block");

  // while cells of a request are still to come no new request is taken
  a_mid_item_busy: assert property (@(posedge clk) disable iff (rst)
    cell_valid && !cell_stall && !last |-> item_stall)
    else $error("new request taken before the last cell");

  // an off-screen position is dropped at once
  a_reject_idle: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && mode == MODE_AT_POS &&
      (pos_col >= 8'(COLUMNS) || pos_row >= 8'(ROWS)) |=> !item_stall)
    else $error("rejected position kept the block busy");

endmodule

bind text_terminal_cell_writer ttcw_checker u_ttcw_checker (.*);
